### src/efpu_pkg.sv
// Shared types, constants and colour coefficients of the escape-time fractal pixel unit.
package efpu_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC = 28;
	localparam int OP_W = 36;
	localparam int PROD_W = 2 * OP_W;
	localparam int NUM_W = 50;
	localparam int DEN_W = 48;
	localparam int QUO_W = 10;

	localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
	localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
	localparam logic [2:0] REG_STEP_RE = 3'd2;
	localparam logic [2:0] REG_STEP_IM = 3'd3;
	localparam logic [2:0] REG_MAX_ITER = 3'd4;
	localparam logic [2:0] REG_RADIUS_SQ = 3'd5;

	localparam logic signed [OP_W-1:0] DEN_SCALE = 36'sd1000000;

	typedef struct packed {
		logic [11:0] pixel_col;
		logic [11:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [15:0] escape_count;
	} result_t;

	function automatic logic signed [OP_W-1:0] coef_a(input logic [1:0] ch);
		logic signed [OP_W-1:0] v;
		case (ch)
			2'd0: v = 36'sd214242075;
			2'd1: v = 36'sd57253875;
			default: v = -36'sd491634900;
		endcase
		return v;
	endfunction

	function automatic logic signed [OP_W-1:0] coef_b(input logic [1:0] ch);
		logic signed [OP_W-1:0] v;
		case (ch)
			2'd0: v = -36'sd326484150;
			2'd1: v = -36'sd12507750;
			default: v = 36'sd1085269800;
		endcase
		return v;
	endfunction

endpackage

### src/escape_time_fractal_pixel_unit.sv
// Escape-time fractal pixel unit: Mandelbrot iteration, smoothing and colour map.
// S_CRE, S_CIM and S_CIM2 form c; S_XX, S_YY, S_XY and S_STEP run each iteration.
// Escaped points then use S_DEN, S_DEN2 and S_CA to S_DIV per colour division.
// One pixel at a time; start is taken only while busy is low.
// The result is shown for one cycle under result_valid; the receiver cannot stall.
// Reset is asynchronous, active low, and restores the default view registers.
module escape_time_fractal_pixel_unit import efpu_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        start,
	input  pixel_t      pixel,
	output logic        busy,
	output logic        result_valid,
	output result_t     result
);

	typedef enum logic [3:0] {
		S_IDLE, S_CRE, S_CIM, S_CIM2, S_XX, S_YY, S_XY, S_STEP,
		S_DEN, S_DEN2, S_CA, S_CB, S_CN, S_DIV
	} state_t;

	localparam logic [PROD_W-1:0] T16 = PROD_W'(16) << (2 * FRAC);
	localparam logic [PROD_W-1:0] T256 = PROD_W'(256) << (2 * FRAC);
	localparam logic [PROD_W:0] T65536 = (PROD_W + 1)'(65536) << (2 * FRAC);

	state_t state_q;

	logic signed [31:0] origin_re_q, origin_im_q, step_re_q, step_im_q;
	logic [15:0]        max_iter_q;
	logic [4:0]         radius_sq_q;

	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COUNT_BITS-1:0] maxit_q, n_q, cnt_q;
	logic [4:0]            r2_q;
	logic signed [31:0]    cre_q, cim_q;
	logic signed [OP_W-1:0] x_q, y_q;
	logic signed [PROD_W-1:0] xx_q, yy_q;
	logic signed [NUM_W-1:0] acc_q;
	logic [DEN_W-1:0]       den_q;
	logic [1:0]             ch_q;
	logic [7:0]             red_q, green_q;
	logic                   valid_q;
	result_t                result_q;

	logic signed [OP_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0] p;
	logic [PROD_W-1:0]        mag;
	logic signed [PROD_W-1:0] dxy, nx_full, ny_full;
	logic [1:0]               sub;
	logic                     div_start, div_done;
	logic signed [NUM_W-1:0]  div_num;
	logic [7:0]               div_value;

	efpu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p)
	);

	efpu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done_q (div_done),
		.value  (div_value)
	);

	always_comb begin
		mul_a = x_q;
		mul_b = x_q;
		case (state_q)
			S_CRE: begin
				mul_a = OP_W'(col_q);
				mul_b = OP_W'(step_re_q);
			end
			S_CIM: begin
				mul_a = OP_W'(row_q);
				mul_b = OP_W'(step_im_q);
			end
			S_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			S_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			S_DEN: begin
				mul_a = OP_W'(maxit_q);
				mul_b = DEN_SCALE;
			end
			S_CA: begin
				mul_a = coef_a(ch_q);
				mul_b = OP_W'(maxit_q);
			end
			S_CB: begin
				mul_a = coef_b(ch_q);
				mul_b = OP_W'(cnt_q);
			end
			default: begin
				mul_a = x_q;
				mul_b = x_q;
			end
		endcase
	end

	assign mag = unsigned'(xx_q) + unsigned'(yy_q);
	assign dxy = xx_q - yy_q;
	assign nx_full = (dxy >>> FRAC) + PROD_W'(cre_q);
	assign ny_full = (p >>> (FRAC - 1)) + PROD_W'(cim_q);
	assign sub = ({1'b0, mag} > T65536) ? 2'd3 : (mag > T256) ? 2'd2 :
		(mag > T16) ? 2'd1 : 2'd0;
	assign div_start = (state_q == S_CN);
	assign div_num = acc_q + NUM_W'(p);

	assign busy = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= -32'sd536870912;
			origin_im_q <= -32'sd268435456;
			step_re_q <= 32'sd262144;
			step_im_q <= 32'sd262144;
			max_iter_q <= 16'd255;
			radius_sq_q <= 5'd4;
		end else if (wr_en) begin
			case (wr_index)
				REG_ORIGIN_RE: origin_re_q <= wr_data;
				REG_ORIGIN_IM: origin_im_q <= wr_data;
				REG_STEP_RE: step_re_q <= wr_data;
				REG_STEP_IM: step_im_q <= wr_data;
				REG_MAX_ITER: max_iter_q <= wr_data[15:0];
				REG_RADIUS_SQ: radius_sq_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						col_q <= COORD_BITS'(pixel.pixel_col);
						row_q <= COORD_BITS'(pixel.pixel_row);
						maxit_q <= COUNT_BITS'(max_iter_q);
						r2_q <= (radius_sq_q < 5'd4) ? 5'd4 : radius_sq_q;
						state_q <= S_CRE;
					end
				end
				S_CRE: state_q <= S_CIM;
				S_CIM: begin
					cre_q <= origin_re_q + p[31:0];
					state_q <= S_CIM2;
				end
				S_CIM2: begin
					cim_q <= origin_im_q + p[31:0];
					x_q <= '0;
					y_q <= '0;
					n_q <= '0;
					state_q <= S_XX;
				end
				S_XX: state_q <= S_YY;
				S_YY: begin
					xx_q <= p;
					state_q <= S_XY;
				end
				S_XY: begin
					yy_q <= p;
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (n_q >= maxit_q) begin
						result_q <= '{red: 8'd0, green: 8'd0, blue: 8'd0,
							escape_count: 16'(maxit_q)};
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (mag > (PROD_W'(r2_q) << (2 * FRAC))) begin
						cnt_q <= (n_q > COUNT_BITS'(sub)) ? n_q - COUNT_BITS'(sub) : '0;
						state_q <= S_DEN;
					end else begin
						x_q <= nx_full[OP_W-1:0];
						y_q <= ny_full[OP_W-1:0];
						n_q <= n_q + COUNT_BITS'(1);
						state_q <= S_XX;
					end
				end
				S_DEN: begin
					ch_q <= 2'd0;
					state_q <= S_DEN2;
				end
				S_DEN2: begin
					den_q <= p[DEN_W-1:0];
					state_q <= S_CA;
				end
				S_CA: state_q <= S_CB;
				S_CB: begin
					acc_q <= p[NUM_W-1:0];
					state_q <= S_CN;
				end
				S_CN: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						case (ch_q)
							2'd0: begin
								red_q <= div_value;
								ch_q <= 2'd1;
								state_q <= S_CA;
							end
							2'd1: begin
								green_q <= div_value;
								ch_q <= 2'd2;
								state_q <= S_CA;
							end
							default: begin
								result_q <= '{red: red_q, green: green_q, blue: div_value,
									escape_count: 16'(cnt_q)};
								valid_q <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/efpu_mul.sv
// Shared signed multiplier with a registered product.
module efpu_mul import efpu_pkg::*; (
	input  logic                     clk,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	output logic signed [PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

### src/efpu_div.sv
// Iterative restoring divider for one colour channel, saturated to 0..255.
module efpu_div import efpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done_q,
	output logic [7:0]              value
);

	localparam int REM_W = DEN_W + QUO_W;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             run_q;
	logic             fits;

	assign fits = rem_q >= dsh_q;
	assign value = (quo_q > QUO_W'(255)) ? 8'd255 : quo_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 4'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1] ? '0 : REM_W'(unsigned'(num));
			dsh_q <= REM_W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

### bench/tb_escape_time_fractal_pixel_unit.sv
// Self-checking testbench for the escape-time fractal pixel unit, with a built-in pixel predictor.
`timescale 1ns / 1ps

module tb_escape_time_fractal_pixel_unit;
	import efpu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = REG_ORIGIN_RE;
	logic [31:0] wr_data = '0;
	logic start = 1'b0;
	pixel_t pixel = '0;
	logic busy;
	logic result_valid;
	result_t result;

	escape_time_fractal_pixel_unit uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .pixel(pixel), .busy(busy), .result_valid(result_valid),
		.result(result)
	);

	always #1 clk = ~clk;

	logic signed [31:0] view_re = -32'sd536870912;
	logic signed [31:0] view_im = -32'sd268435456;
	logic signed [31:0] col_step = 32'sd262144;
	logic signed [31:0] row_step = 32'sd262144;
	logic [15:0] iter_limit = 16'd255;
	logic [4:0] radius_sq = 5'd4;

	pixel_t pending_pixels[$];
	result_t expected_colours[$];
	int idle_pct = 0;
	int errors = 0;
	int pixels_sent = 0;
	int colours_seen = 0;
	int in_set_seen = 0;
	logic took = 1'b0;

	function automatic logic beyond(logic signed [63:0] x, logic signed [63:0] y,
			logic [16:0] t);
		logic signed [127:0] xw;
		logic signed [127:0] yw;
		logic signed [127:0] s;
		xw = x;
		yw = y;
		s = xw * xw + yw * yw;
		return s > (128'(t) << 56);
	endfunction

	function automatic logic [7:0] channel_level(longint num, longint den);
		longint q;
		if (num < 0)
			return 8'd0;
		q = num / den;
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	function automatic result_t predict_pixel(pixel_t p);
		longint wide_re;
		longint wide_im;
		logic signed [31:0] c32;
		logic signed [63:0] cre;
		logic signed [63:0] cim;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [127:0] xw;
		logic signed [127:0] yw;
		logic signed [127:0] tmp;
		logic signed [63:0] nx;
		logic [16:0] r2;
		int n;
		int sub;
		int cnt;
		longint m;
		longint den;
		result_t r;
		wide_re = longint'(view_re) + longint'(p.pixel_col) * longint'(col_step);
		wide_im = longint'(view_im) + longint'(p.pixel_row) * longint'(row_step);
		c32 = wide_re[31:0];
		cre = c32;
		c32 = wide_im[31:0];
		cim = c32;
		r2 = radius_sq < 5'd4 ? 17'd4 : 17'(radius_sq);
		x = 0;
		y = 0;
		n = 0;
		while (n < iter_limit && !beyond(x, y, r2)) begin
			xw = x;
			yw = y;
			tmp = (xw * xw - yw * yw) >>> FRAC;
			nx = tmp[63:0] + cre;
			tmp = (2 * xw * yw) >>> FRAC;
			y = tmp[63:0] + cim;
			x = nx;
			n++;
		end
		if (n >= iter_limit) begin
			r = '0;
			r.escape_count = iter_limit;
		end else begin
			sub = 0;
			if (beyond(x, y, 17'd16))
				sub = 1;
			if (beyond(x, y, 17'd256))
				sub = 2;
			if (beyond(x, y, 17'd65536))
				sub = 3;
			cnt = n > sub ? n - sub : 0;
			m = iter_limit;
			den = m * 1000000;
			r.red = channel_level(214242075 * m - 326484150 * longint'(cnt), den);
			r.green = channel_level(57253875 * m - 12507750 * longint'(cnt), den);
			r.blue = channel_level(-491634900 * m + 1085269800 * longint'(cnt), den);
			r.escape_count = cnt[15:0];
		end
		return r;
	endfunction

	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				pixel <= pending_pixels.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		took <= start && !busy;
		if (arst_n && start && !busy) begin
			expected_colours.push_back(predict_pixel(pixel));
			pixels_sent++;
		end
		if (arst_n && result_valid) begin
			colours_seen++;
			if (expected_colours.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, actual %h", $time, result);
			end else begin
				want = expected_colours.pop_front();
				if (want.escape_count == iter_limit && want.red == 0)
					in_set_seen++;
				if (result.red !== want.red)
					$display("%0t: red expected %0d actual %0d", $time, want.red, result.red);
				if (result.green !== want.green)
					$display("%0t: green expected %0d actual %0d", $time, want.green,
						result.green);
				if (result.blue !== want.blue)
					$display("%0t: blue expected %0d actual %0d", $time, want.blue,
						result.blue);
				if (result.escape_count !== want.escape_count)
					$display("%0t: count expected %0d actual %0d", $time,
						want.escape_count, result.escape_count);
				if (result !== want)
					errors++;
			end
		end
	end

	task automatic settle();
		do
			@(posedge clk);
		while (pending_pixels.size() != 0 || expected_colours.size() != 0 || start || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ORIGIN_RE: view_re = val;
			REG_ORIGIN_IM: view_im = val;
			REG_STEP_RE: col_step = val;
			REG_STEP_IM: row_step = val;
			REG_MAX_ITER: iter_limit = val[15:0];
			REG_RADIUS_SQ: radius_sq = val[4:0];
			default: ;
		endcase
	endtask

	task automatic queue_pixel(int col, int row);
		pixel_t p;
		p.pixel_col = 12'(col);
		p.pixel_row = 12'(row);
		pending_pixels.push_back(p);
	endtask

	function automatic logic [31:0] pick_step();
		logic [31:0] s;
		s = $urandom_range(1 << 20, 1) >> $urandom_range(10);
		return $urandom_range(1) ? -s : s;
	endfunction

	initial begin
		static int phase_idle[4] = '{0, 63, 0, 37};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		queue_pixel(4095, 0);
		queue_pixel(0, 4095);
		queue_pixel(2048, 1024);
		queue_pixel(1600, 1024);
		queue_pixel(2300, 1500);
		queue_pixel(1200, 1300);
		settle();
		write_reg(REG_MAX_ITER, 32'd0);
		queue_pixel(2048, 1024);
		settle();
		write_reg(REG_MAX_ITER, 32'd1);
		queue_pixel(0, 0);
		queue_pixel(2048, 1024);
		settle();
		write_reg(REG_MAX_ITER, 32'd40);
		write_reg(REG_RADIUS_SQ, 32'd0);
		queue_pixel(1000, 900);
		queue_pixel(2400, 1300);
		settle();
		write_reg(REG_RADIUS_SQ, 32'd31);
		queue_pixel(1000, 900);
		queue_pixel(2400, 1300);
		settle();
		write_reg(REG_RADIUS_SQ, 32'd16);
		write_reg(REG_STEP_RE, 32'h8000_0000);
		write_reg(REG_STEP_IM, 32'h7FFF_FFFF);
		write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
		write_reg(REG_ORIGIN_IM, 32'h8000_0000);
		queue_pixel(4095, 4095);
		queue_pixel(1, 3);
		queue_pixel(0, 0);
		settle();
		write_reg(REG_MAX_ITER, 32'd65535);
		write_reg(REG_ORIGIN_RE, 32'h0);
		write_reg(REG_ORIGIN_IM, 32'h0);
		write_reg(REG_STEP_RE, 32'h0001_0000);
		write_reg(REG_STEP_IM, 32'h0001_0000);
		queue_pixel(0, 0);
		queue_pixel(4095, 4095);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = phase_idle[ph % 4];
			if (ph % 3 == 2) begin
				write_reg(REG_ORIGIN_RE, $urandom());
				write_reg(REG_ORIGIN_IM, $urandom());
				write_reg(REG_STEP_RE, $urandom());
				write_reg(REG_STEP_IM, $urandom());
			end else begin
				write_reg(REG_ORIGIN_RE, -32'sd536870912 - $urandom_range(1 << 27));
				write_reg(REG_ORIGIN_IM, -32'sd268435456 - $urandom_range(1 << 27));
				write_reg(REG_STEP_RE, pick_step());
				write_reg(REG_STEP_IM, pick_step());
			end
			write_reg(REG_MAX_ITER, $urandom_range(64, 1));
			write_reg(REG_RADIUS_SQ, $urandom_range(31));
			for (int k = 0; k < 250; k++) begin
				if ($urandom_range(3) == 0)
					queue_pixel($urandom_range(4095), $urandom_range(4095));
				else
					queue_pixel($urandom_range(1023), $urandom_range(1023));
			end
			settle();
		end

		repeat (60) @(posedge clk);
		$display("Run covered %0d pixels and %0d colour transfers, %0d of them inside the set.",
			pixels_sent, colours_seen, in_set_seen);
		if (errors == 0 && expected_colours.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
